// ----- sv/mpqd_pkg.sv -----
// Shared types and constants for the min priority queue with delete.
// Holds the queue depth, field widths, command and status codes, and the
// structs passed between the top level and the sorted cell chain.
package mpqd_pkg;

   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 7;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_DELETE  = 2'd1,
      CMD_QUERY   = 2'd2,
      CMD_INVALID = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_BAD_CMD   = 3'd4
   } status_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      logic      valid;
      value_type entry;
      logic      gt;     // empty, or entry greater than the broadcast value
      logic      ge;     // empty, or entry greater than or equal to it
   } link_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic      insert;   // insert the value, shift larger entries up
      logic      capture;  // latch delete match flags
      logic      shift;    // remove the matched entry, shift larger ones down
      value_type value;
   } cell_ctl_type;

endpackage

// ----- sv/mpqd_cell.sv -----
// One cell of the sorted chain: holds a single entry and its valid bit.
// Depends on mpqd_pkg for the link and control structs.
module mpqd_cell
   import mpqd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  link_type     left,
   input  link_type     right,
   output link_type     link,
   output logic         hit
);

   logic      valid_ff, valid_in;
   value_type entry_ff, entry_in;
   logic      ge_ff, hit_ff;
   logic      gt, ge, match;

   assign gt    = !valid_ff || (entry_ff > ctl.value);
   assign ge    = !valid_ff || (entry_ff >= ctl.value);
   // first entry not below the value, and equal to it
   assign match = valid_ff && (entry_ff == ctl.value) && !left.ge;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctl.insert && gt) begin
         entry_in = left.gt ? left.entry : ctl.value;
         valid_in = valid_ff | left.valid;
      end else if (ctl.shift && ge_ff) begin
         entry_in = right.entry;
         valid_in = right.valid;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.capture) begin
            hit_ff <= match;
         end
      end
      entry_ff <= entry_in;
      if (ctl.capture) begin
         ge_ff <= ge;
      end
   end

   assign link = '{valid: valid_ff, entry: entry_ff, gt: gt, ge: ge};
   assign hit  = hit_ff;

endmodule

// ----- sv/min_priority_queue_with_delete.sv -----
// Top level of the min priority queue with delete: a sorted chain of cells,
// the occupancy counter, the command sequencer and the result register.
// Depends on mpqd_pkg and mpqd_cell.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   request | req_valid req_stall req_cmd        | in
//           | req_value                          |
//   result  | rsp_valid rsp_stall rsp_status     | out
//           | rsp_min_value rsp_occupancy        |
//
// Insert, query and unknown commands finish from the idle state; for an insert
// every cell compares against the value in parallel and the chain shifts up in
// the same edge. Delete passes through the shift state: match flags are latched
// in every cell, then their OR decides whether the chain shifts down.
// Synchronous reset empties the queue (valid bits only, no clearing pass).
// A result held by rsp_stall blocks the next request; one taken in a cycle
// lets a new request transfer in that same cycle.
module min_priority_queue_with_delete
   import mpqd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_min_value,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SHIFT = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   count_type    count_ff, count_in;
   status_type   status_ff, status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         accept, full, found, done_now;
   cmd_type      cmd;
   cell_ctl_type ctl;
   link_type     links [CAPACITY];
   logic [CAPACITY-1:0] hits;

   assign cmd       = cmd_type'(req_cmd);
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == COUNT_W'(CAPACITY));
   assign found     = |hits;

   assign ctl.insert  = accept && (cmd == CMD_INSERT) && !full;
   assign ctl.capture = accept && (cmd == CMD_DELETE);
   assign ctl.shift   = (state_ff == ST_SHIFT) && found;
   assign ctl.value   = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      link_type left_link, right_link;
      if (i == 0) begin : g_first
         assign left_link = '{valid: 1'b1, entry: '0, gt: 1'b0, ge: 1'b0};
      end else begin : g_inner_left
         assign left_link = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_link = '{valid: 1'b0, entry: '0, gt: 1'b1, ge: 1'b1};
      end else begin : g_inner_right
         assign right_link = links[i+1];
      end
      mpqd_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .left  (left_link),
         .right (right_link),
         .link  (links[i]),
         .hit   (hits[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      done_now  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_INSERT: begin
                     done_now  = 1'b1;
                     status_in = full ? STATUS_FULL : STATUS_OK;
                     if (!full) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     state_in = ST_SHIFT;
                  end
                  CMD_QUERY: begin
                     done_now  = 1'b1;
                     status_in = (count_ff == '0) ? STATUS_EMPTY : STATUS_OK;
                  end
                  default: begin
                     done_now  = 1'b1;
                     status_in = STATUS_BAD_CMD;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            done_now  = 1'b1;
            state_in  = ST_IDLE;
            status_in = found ? STATUS_OK : STATUS_NOT_FOUND;
            if (found) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (done_now) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;   // drop once the result transfers
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
   end

   // The head cell holds the minimum; it only changes when a result is issued.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_min_value = links[0].valid ? links[0].entry : '0;
   assign rsp_occupancy = OCC_W'(count_ff);

endmodule
